### src/bbsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsr_pkg
// Shared types, constants and the charge word function of the bit-banged
// battery slot responder.
// ----------------------------------------------------------------------------
package bbsr_pkg;

  localparam int CMD_WRITE_BITS_DEF = 16;
  localparam int RESP_BYTES_DEF     = 32;

  localparam logic [7:0]  DIR_REG_OFFSET = 8'h14;
  localparam int          PIN_BIT        = 9;
  localparam logic [1:0]  PIN_BANK       = 2'd2;
  localparam logic [9:0]  PIN_WORD       = 10'h200;
  localparam logic [12:0] FULL_LEVEL     = 13'd4200;
  localparam logic [12:0] EMPTY_LEVEL    = 13'd210;
  localparam logic [6:0]  FILL_CAP       = 7'd100;

  localparam logic MODE_DIR_WRITE  = 1'b0;
  localparam logic MODE_LEVEL_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  write_offset;
    logic [31:0] write_value;
    logic [1:0]  read_bank;
  } bbsr_req_t;

  // level = 210 + fill*3990/100 = 210 + 40*fill - ceil(fill/10), fill <= 100
  function automatic logic [14:0] charge_word(input logic [6:0] fill_in);
    logic [6:0]  f;
    logic [14:0] prod;
    logic [12:0] lvl;
    f    = (fill_in > FILL_CAP) ? FILL_CAP : fill_in;
    prod = ({8'd0, f} + 15'd9) * 15'd205;
    lvl  = EMPTY_LEVEL + ({6'd0, f} * 13'd40) - 13'(prod >> 11);
    return {lvl, 2'b00};
  endfunction

endpackage

### src/bitbang_battery_slot_responder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitbang_battery_slot_responder_unit
// Single-wire battery slave that follows a host bit-banging its GPIO pin.
//
// Requests come in on in_* (valid/stall): mode 0 is a direction register
// write, mode 1 a pin level read. Writes give no result; each read gives one
// result on out_* carrying read_word (0x200 when the pin is driven high).
// cfg_we/cfg_wdata load the fill percentage; write it only while idle.
// A request is registered in the input register, then processed into the
// result register. One request per cycle is taken sustained while no read
// waits on a stalled result; the slot update between the input and result
// registers is combinational. When out_stall is high the result holds
// and reads back up; a write at the head still passes. Synchronous reset (rst_n
// low) clears all slot state, the fill percentage and both valid flags.
// ----------------------------------------------------------------------------
module bitbang_battery_slot_responder_unit
  import bbsr_pkg::*;
#(
  parameter int CMD_WRITE_BITS = CMD_WRITE_BITS_DEF,
  parameter int RESP_BYTES     = RESP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_write_offset,
  input  logic [31:0] in_write_value,
  input  logic [1:0]  in_read_bank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_read_word
);

  logic [6:0] fill_r;
  logic       out_valid_r;
  logic [9:0] out_word_r;
  bbsr_req_t  req_in;
  bbsr_req_t  req;
  logic       req_valid;
  logic       out_free;
  logic       consume;
  logic       emit;
  logic [9:0] word;

  assign req_in = '{mode: in_mode, write_offset: in_write_offset,
                    write_value: in_write_value, read_bank: in_read_bank};

  assign out_free = !out_valid_r || !out_stall;
  assign consume  = req_valid && (req.mode == MODE_DIR_WRITE || out_free);
  assign emit     = consume && req.mode == MODE_LEVEL_READ;

  bbsr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_in    (req_in),
    .consume   (consume),
    .req_valid (req_valid),
    .req_out   (req)
  );

  bbsr_slot_core #(
    .CMD_WRITE_BITS (CMD_WRITE_BITS),
    .RESP_BYTES     (RESP_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (consume),
    .req          (req),
    .fill_percent (fill_r),
    .read_word    (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;

endmodule

### src/bbsr_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsr_in_reg
// Input request register. Holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module bbsr_in_reg
  import bbsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bbsr_req_t req_in,
  input  logic      consume,
  output logic      req_valid,
  output bbsr_req_t req_out
);

  logic      valid_r;
  logic      valid_nxt;
  bbsr_req_t req_r;
  logic      load;

  assign in_stall  = valid_r && !consume;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= req_in;
    end
  end

  assign req_valid = valid_r;
  assign req_out   = req_r;

endmodule

### src/bbsr_slot_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsr_slot_core
// Slot framing, write bit counting and response bit serving.
// ----------------------------------------------------------------------------
module bbsr_slot_core
  import bbsr_pkg::*;
#(
  parameter int CMD_WRITE_BITS = CMD_WRITE_BITS_DEF,
  parameter int RESP_BYTES     = RESP_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  bbsr_req_t  req,
  input  logic [6:0] fill_percent,
  output logic [9:0] read_word
);

  localparam int CNT_W     = $clog2(CMD_WRITE_BITS + 1);
  localparam int RESP_BITS = 8 * RESP_BYTES;
  localparam int IDX_W     = $clog2(RESP_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(CMD_WRITE_BITS);
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(RESP_BITS);
  localparam logic [IDX_W-1:0] BYTE_0   = IDX_W'(0);
  localparam logic [IDX_W-1:0] BYTE_1   = IDX_W'(1);
  localparam logic [IDX_W-1:0] BYTE_4   = IDX_W'(4);
  localparam logic [IDX_W-1:0] BYTE_5   = IDX_W'(5);

  logic             pin_out_r,  pin_out_nxt;
  logic             armed_r,    armed_nxt;
  logic             last_rd_r,  last_rd_nxt;
  logic             serving_r,  serving_nxt;
  logic [CNT_W-1:0] wr_cnt_r,   wr_cnt_nxt;
  logic [IDX_W-1:0] idx_r,      idx_nxt;
  logic [14:0]      cw_r,       cw_nxt;

  logic             dir_out;
  logic [IDX_W-1:0] idx_cur;
  logic [IDX_W-1:0] byte_sel;
  logic [7:0]       byte_val;
  logic [CNT_W-1:0] cnt_base;

  assign dir_out  = req.write_value[PIN_BIT];
  assign idx_cur  = serving_r ? idx_r : '0;
  assign byte_sel = idx_cur >> 3;

  always_comb begin
    byte_val = 8'd0;
    if (byte_sel == BYTE_0) begin
      byte_val = FULL_LEVEL[12:8] == 5'd0 ? 8'd0 : {3'd0, FULL_LEVEL[12:8]};
    end else if (byte_sel == BYTE_1) begin
      byte_val = FULL_LEVEL[7:0];
    end else if (byte_sel == BYTE_4) begin
      byte_val = {1'b0, cw_r[14:8]};
    end else if (byte_sel == BYTE_5) begin
      byte_val = cw_r[7:0];
    end
  end

  always_comb begin
    pin_out_nxt = pin_out_r;
    armed_nxt   = armed_r;
    last_rd_nxt = last_rd_r;
    serving_nxt = serving_r;
    wr_cnt_nxt  = wr_cnt_r;
    idx_nxt     = idx_r;
    cw_nxt      = cw_r;
    cnt_base    = wr_cnt_r;
    read_word   = 10'd0;
    if (fire && req.mode == MODE_DIR_WRITE) begin
      if (req.write_offset == DIR_REG_OFFSET) begin
        if (dir_out && !pin_out_r) begin
          if (armed_r) begin
            if (last_rd_r) begin
              cnt_base    = '0;
              serving_nxt = 1'b0;
              idx_nxt     = '0;
              last_rd_nxt = 1'b0;
            end
            wr_cnt_nxt = (cnt_base < CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
            armed_nxt  = 1'b0;
          end
          pin_out_nxt = 1'b1;
        end else if (!dir_out && pin_out_r) begin
          armed_nxt   = 1'b1;
          pin_out_nxt = 1'b0;
        end
      end
    end else if (fire && req.mode == MODE_LEVEL_READ) begin
      if (req.read_bank == PIN_BANK && armed_r) begin
        armed_nxt   = 1'b0;
        last_rd_nxt = 1'b1;
        if (wr_cnt_r >= CNT_MAX) begin
          if (!serving_r) begin
            serving_nxt = 1'b1;
            cw_nxt      = charge_word(fill_percent);
          end
          idx_nxt = idx_cur;
          if (idx_cur < IDX_MAX) begin
            read_word = byte_val[idx_cur[2:0]] ? PIN_WORD : 10'd0;
            idx_nxt   = idx_cur + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_out_r <= 1'b0;
      armed_r   <= 1'b0;
      last_rd_r <= 1'b0;
      serving_r <= 1'b0;
      wr_cnt_r  <= '0;
      idx_r     <= '0;
      cw_r      <= '0;
    end else begin
      pin_out_r <= pin_out_nxt;
      armed_r   <= armed_nxt;
      last_rd_r <= last_rd_nxt;
      serving_r <= serving_nxt;
      wr_cnt_r  <= wr_cnt_nxt;
      idx_r     <= idx_nxt;
      cw_r      <= cw_nxt;
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n) wr_cnt_r <= CNT_MAX)
    else $error("write bit count above threshold");
  a_idx_max: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= IDX_MAX)
    else $error("response index past end");
  a_serve_cnt: assert property (@(posedge clk) disable iff (!rst_n)
      serving_r |-> wr_cnt_r == CNT_MAX)
    else $error("serving before command complete");
  a_armed_in: assert property (@(posedge clk) disable iff (!rst_n)
      armed_r |-> !pin_out_r)
    else $error("slot armed while pin is output");
  a_reset: assert property (@(posedge clk) !rst_n |=> (!armed_r && !serving_r && idx_r == '0))
    else $error("state not cleared by reset");

endmodule
